/* hdl/kvt_pkg.sv */
// Shared types and constants for the key/value table.
// Used by the controller and the top level; depends on nothing.
package kvt_pkg;

    localparam int DATA_W = 32;

    // Request codes carried on the opcode port.
    localparam logic [1:0] OP_UPSERT = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Result fields of one transaction, excluding the parameter-sized count.
    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic                     dropped;
    } result_t;

    // Write enables for the key and value memories.
    typedef struct packed {
        logic key_we;
        logic val_we;
    } wr_en_t;

endpackage

/* hdl/kvt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/kvt_ctrl.sv */
// Request sequencer: for an upsert or lookup, scans the key memory from newest
// to oldest entry; then applies the update, insert or lookup. Depends on kvt_pkg.
module kvt_ctrl #(
    parameter int CAPACITY = 64,
    parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         opcode,
    input  logic signed [kvt_pkg::DATA_W-1:0]  key,
    input  logic signed [kvt_pkg::DATA_W-1:0]  value,
    output logic [IDX_W-1:0]                   raddr,
    input  logic [kvt_pkg::DATA_W-1:0]         key_rdata,
    input  logic [kvt_pkg::DATA_W-1:0]         val_rdata,
    output kvt_pkg::wr_en_t                    wr_en,
    output logic [IDX_W-1:0]                   waddr,
    output logic [kvt_pkg::DATA_W-1:0]         key_wdata,
    output logic [kvt_pkg::DATA_W-1:0]         val_wdata,
    output logic                               res_valid,
    input  logic                               res_take,
    output kvt_pkg::result_t                   res,
    output logic [CNT_W-1:0]                   res_count
);

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESP} state_t;

    state_t                            state_reg, state_next;
    logic [1:0]                        op_reg, op_next;
    logic [kvt_pkg::DATA_W-1:0]        key_reg, key_next;
    logic [kvt_pkg::DATA_W-1:0]        val_reg, val_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [IDX_W-1:0]                  scan_idx_reg, scan_idx_next;
    logic                              more_reg, more_next;
    logic                              rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]                  rd_idx_reg, rd_idx_next;
    kvt_pkg::result_t                  res_reg, res_next;
    logic                              hit;
    logic                              full;

    assign hit       = rd_valid_reg && (key_rdata == key_reg);
    assign full      = (count_reg >= CAP_C);
    assign raddr     = scan_idx_reg;
    assign key_wdata = key_reg;
    assign val_wdata = val_reg;
    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;
    assign res_count = count_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        more_next     = more_reg;
        rd_valid_next = rd_valid_reg;
        rd_idx_next   = rd_idx_reg;
        res_next      = res_reg;
        wr_en         = '0;
        waddr         = rd_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = opcode;
                    key_next      = key;
                    val_next      = value;
                    scan_idx_next = IDX_W'(count_reg - 1'b1);
                    more_next     = ((opcode == kvt_pkg::OP_UPSERT) ||
                                     (opcode == kvt_pkg::OP_LOOKUP)) &&
                                    (count_reg != '0);
                    rd_valid_next = 1'b0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (hit || (!rd_valid_reg && !more_reg))
                begin
                    // Scan finished: apply the request and form the result.
                    res_next      = '0;
                    rd_valid_next = 1'b0;
                    more_next     = 1'b0;
                    state_next    = S_RESP;
                    case (op_reg)
                        kvt_pkg::OP_UPSERT, kvt_pkg::OP_INSERT:
                        begin
                            if ((op_reg == kvt_pkg::OP_UPSERT) && hit)
                            begin
                                wr_en.val_we   = 1'b1;
                                waddr          = rd_idx_reg;
                                res_next.found = 1'b1;
                            end
                            else if (full)
                            begin
                                res_next.dropped = 1'b1;
                            end
                            else
                            begin
                                wr_en.key_we = 1'b1;
                                wr_en.val_we = 1'b1;
                                waddr        = count_reg[IDX_W-1:0];
                                count_next   = count_reg + 1'b1;
                            end
                        end
                        kvt_pkg::OP_LOOKUP:
                        begin
                            if (hit)
                            begin
                                res_next.read_value = val_rdata;
                                res_next.found      = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
                else
                begin
                    // Issue the next read while the previous one is compared.
                    rd_valid_next = more_reg;
                    rd_idx_next   = scan_idx_reg;
                    if (more_reg)
                    begin
                        more_next     = (scan_idx_reg != '0);
                        scan_idx_next = scan_idx_reg - 1'b1;
                    end
                end
            end

            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            more_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            more_reg     <= more_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        scan_idx_reg <= scan_idx_next;
        rd_idx_reg   <= rd_idx_next;
        res_reg      <= res_next;
    end

endmodule

/* hdl/key_value_table.sv */
// Key/value table of CAPACITY signed 32-bit pairs held in insertion order in two
// memories. An insert or unused opcode skips the scan; an upsert or lookup scans
// the N stored pairs, N being the pair count: the key memory has a single read
// port and the scan reads one entry a cycle, newest first, stopping at the first
// match. A lookup returns the newest matching value. Memory contents are undefined
// after reset; only the pair count is cleared, and no entry at or above the count
// is ever used. A result may wait in the output register while the next
// transaction is accepted.
// Depends on kvt_pkg, kvt_ram and kvt_ctrl.
module key_value_table #(
    parameter int CAPACITY = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             opcode,
    input  logic signed [kvt_pkg::DATA_W-1:0]      key,
    input  logic signed [kvt_pkg::DATA_W-1:0]      value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [kvt_pkg::DATA_W-1:0]      read_value,
    output logic                                   found,
    output logic                                   dropped,
    output logic [$clog2(CAPACITY + 1)-1:0]        entry_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [IDX_W-1:0]           raddr;
    logic [IDX_W-1:0]           waddr;
    logic [kvt_pkg::DATA_W-1:0] key_rdata, val_rdata;
    logic [kvt_pkg::DATA_W-1:0] key_wdata, val_wdata;
    kvt_pkg::wr_en_t            wr_en;
    logic                       res_valid;
    logic                       res_take;
    kvt_pkg::result_t           res;
    logic [CNT_W-1:0]           res_count;

    logic                       out_valid_reg;
    kvt_pkg::result_t           out_res_reg;
    logic [CNT_W-1:0]           out_count_reg;

    kvt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .key       (key),
        .value     (value),
        .raddr     (raddr),
        .key_rdata (key_rdata),
        .val_rdata (val_rdata),
        .wr_en     (wr_en),
        .waddr     (waddr),
        .key_wdata (key_wdata),
        .val_wdata (val_wdata),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .res_count (res_count)
    );

    kvt_ram #(
        .WIDTH (kvt_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (wr_en.key_we),
        .waddr (waddr),
        .wdata (key_wdata),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    kvt_ram #(
        .WIDTH (kvt_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk   (clk),
        .we    (wr_en.val_we),
        .waddr (waddr),
        .wdata (val_wdata),
        .raddr (raddr),
        .rdata (val_rdata)
    );

    // The output register is free when empty or being emptied this cycle.
    assign res_take = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_res_reg   <= res;
            out_count_reg <= res_count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = out_res_reg.read_value;
    assign found       = out_res_reg.found;
    assign dropped     = out_res_reg.dropped;
    assign entry_count = out_count_reg;

endmodule

/* hdl/kvt_checker.sv */
// Port-level checks for key_value_table, attached by the bind below.
// Sees only the top-level ports; no package dependency.
module kvt_checker #(
    parameter int CAPACITY = 64
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [31:0]                  read_value,
    input logic                                found,
    input logic                                dropped,
    input logic [$clog2(CAPACITY + 1)-1:0]     entry_count
);

    localparam logic [$clog2(CAPACITY + 1)-1:0] CAP_C = ($clog2(CAPACITY + 1))'(CAPACITY);

    a_found_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && dropped))
        else $error("found and dropped both set in one transaction");

    a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (read_value == 0))
        else $error("non-zero read_value without a hit");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= CAP_C))
        else $error("entry_count above capacity");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped) |-> (entry_count == CAP_C))
        else $error("insertion dropped while the table had room");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(read_value) &&
                                      $stable(found) && $stable(dropped) &&
                                      $stable(entry_count)))
        else $error("stalled result changed");

endmodule

bind key_value_table kvt_checker #(
    .CAPACITY (CAPACITY)
) u_kvt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .found       (found),
    .dropped     (dropped),
    .entry_count (entry_count)
);

/* sim/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for key_value_table: queued requests, a predicting monitor and
// phases of sender and receiver idling. Depends on kvt_pkg and the key_value_table RTL.
module tb;

    localparam int          DATA_W      = kvt_pkg::DATA_W;
    localparam int          CAP         = 64;
    localparam int          CNT_W       = $clog2(CAP + 1);
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          HOLD_CYCLES = 300;
    localparam int          STALL_LIMIT = 4000;
    localparam int          DRAIN_WAIT  = CAP + 16;
    localparam int          PHASE_ITEMS = 333;
    localparam int          MAX_PRINTS  = 50;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] k;
        logic signed [DATA_W-1:0] v;
    } request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic                     dropped;
        logic [CNT_W-1:0]         count;
    } reply_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic [1:0]               opcode    = '0;
    logic signed [DATA_W-1:0] key       = '0;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     out_stall = 1'b0;
    wire                      in_stall;
    wire                      out_valid;
    wire signed [DATA_W-1:0]  read_value;
    wire                      found;
    wire                      dropped;
    wire [CNT_W-1:0]          entry_count;

    key_value_table #(
        .CAPACITY (CAP)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .found       (found),
        .dropped     (dropped),
        .entry_count (entry_count)
    );

    always #6 clk = ~clk;

    // Shadow copy of the table contents, in insertion order.
    logic signed [DATA_W-1:0] shadow_keys [CAP];
    logic signed [DATA_W-1:0] shadow_vals [CAP];
    int                       shadow_pairs = 0;

    request_t request_queue [$];
    reply_t   awaited_replies [$];

    logic in_took        = 1'b0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   holds_asked    = 0;
    int   holds_served   = 0;
    int   hold_left      = 0;
    int   idle_cycles    = 0;
    int   errors         = 0;
    int   requests_seen  = 0;
    int   replies_seen   = 0;
    int   lookup_hits    = 0;
    int   drops_seen     = 0;
    int   peak_pairs     = 0;

    logic signed [DATA_W-1:0] key_pool [12];

    function automatic reply_t predict_reply(request_t rq);
        reply_t r;
        int     hit;
        r   = '0;
        hit = -1;
        if (rq.op == kvt_pkg::OP_UPSERT || rq.op == kvt_pkg::OP_LOOKUP)
        begin
            for (int i = shadow_pairs - 1; i >= 0; i--)
            begin
                if (hit < 0 && shadow_keys[i] == rq.k)
                    hit = i;
            end
        end
        case (rq.op)
            kvt_pkg::OP_UPSERT, kvt_pkg::OP_INSERT:
            begin
                if (rq.op == kvt_pkg::OP_UPSERT && hit >= 0)
                begin
                    shadow_vals[hit] = rq.v;
                    r.found = 1'b1;
                end
                else if (shadow_pairs >= CAP)
                    r.dropped = 1'b1;
                else
                begin
                    shadow_keys[shadow_pairs] = rq.k;
                    shadow_vals[shadow_pairs] = rq.v;
                    shadow_pairs++;
                end
            end
            kvt_pkg::OP_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    r.read_value = shadow_vals[hit];
                    r.found      = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = CNT_W'(shadow_pairs);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t: mismatch on %s in reply %0d: got %h, expected %h",
                     $realtime, what, replies_seen, got, want);
    endtask

    task automatic queue_request(logic [1:0] op, logic signed [DATA_W-1:0] k,
                                 logic signed [DATA_W-1:0] v);
        request_t rq;
        rq.op = op;
        rq.k  = k;
        rq.v  = v;
        request_queue.push_back(rq);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_key();
        if ($urandom_range(99) < 5)
            return $urandom;
        return key_pool[$urandom_range(11)];
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(99) < 5)
            return key_pool[$urandom_range(3)];
        return $urandom;
    endfunction

    // Checked at the rising edge, where the driver's outputs have settled.
    task automatic wait_for_drain();
        while (request_queue.size() != 0 || in_valid || awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    // Sampling at the rising edge: check the result first, then predict the new request.
    always @(posedge clk)
    begin : watch_ports
        reply_t want;
        reply_t got;
        request_t rq;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_replies.size() == 0)
                    report_mismatch("reply with none pending", read_value, '0);
                else
                begin
                    want = awaited_replies.pop_front();
                    if (read_value !== want.read_value)
                        report_mismatch("read_value", read_value, want.read_value);
                    if (found !== want.found)
                        report_mismatch("found", found, want.found);
                    if (dropped !== want.dropped)
                        report_mismatch("dropped", dropped, want.dropped);
                    if (entry_count !== want.count)
                        report_mismatch("entry_count", entry_count, want.count);
                end
                replies_seen++;
            end
            if (in_valid && !in_stall)
            begin
                rq.op = opcode;
                rq.k  = key;
                rq.v  = value;
                got   = predict_reply(rq);
                awaited_replies.push_back(got);
                requests_seen++;
                if (rq.op == kvt_pkg::OP_LOOKUP && got.found)
                    lookup_hits++;
                if (got.dropped)
                    drops_seen++;
                if (shadow_pairs > peak_pairs)
                    peak_pairs = shadow_pairs;
                in_took <= 1'b1;
            end
            else
                in_took <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : drive_requests
        request_t rq;
        if (rst_n && (!in_valid || in_took))
        begin
            if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                rq = request_queue.pop_front();
                in_valid <= 1'b1;
                opcode   <= rq.op;
                key      <= rq.k;
                value    <= rq.v;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // A long hold-off lets the single output register fill and back up the input.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (holds_served < holds_asked)
        begin
            out_stall    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timed out after %0d cycles without a transaction", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int r;
        int insert_pct;
        logic signed [DATA_W-1:0] k_min;
        logic signed [DATA_W-1:0] k_max;
        k_min = {1'b1, {(DATA_W-1){1'b0}}};
        k_max = {1'b0, {(DATA_W-1){1'b1}}};
        key_pool[0] = k_min;
        key_pool[1] = k_max;
        key_pool[2] = '0;
        key_pool[3] = '1;
        for (int i = 4; i < 12; i++)
            key_pool[i] = $urandom;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty table, extremes, replacement, duplicates, unused opcode.
        queue_request(kvt_pkg::OP_LOOKUP, '0, 32'sd5);
        queue_request(kvt_pkg::OP_UPSERT, k_min, k_max);
        queue_request(kvt_pkg::OP_UPSERT, k_max, k_min);
        queue_request(kvt_pkg::OP_INSERT, '0, '1);
        queue_request(kvt_pkg::OP_INSERT, '1, '0);
        queue_request(kvt_pkg::OP_LOOKUP, k_min, '0);
        queue_request(kvt_pkg::OP_LOOKUP, k_max, '0);
        queue_request(kvt_pkg::OP_LOOKUP, '0, '0);
        queue_request(kvt_pkg::OP_UPSERT, k_min, 32'sh12345678);
        queue_request(kvt_pkg::OP_LOOKUP, k_min, '1);
        queue_request(kvt_pkg::OP_INSERT, k_min, 32'sh55aa55aa);
        queue_request(kvt_pkg::OP_LOOKUP, k_min, '0);
        queue_request(kvt_pkg::OP_UPSERT, k_min, 32'sd1);
        queue_request(kvt_pkg::OP_LOOKUP, k_min, '0);
        queue_request(OP_UNUSED, k_max, 32'sd7);
        queue_request(kvt_pkg::OP_LOOKUP, 32'sd12345, '0);
        queue_request(kvt_pkg::OP_LOOKUP, k_max, '0);
        queue_request(kvt_pkg::OP_UPSERT, '1, k_max);
        queue_request(kvt_pkg::OP_LOOKUP, '1, '0);
        queue_request(kvt_pkg::OP_LOOKUP, 32'sd1, '0);
        wait_for_drain();

        // Random phases; the sender pauses after each until every reply is back.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 21 : 0;
            recv_stall_pct = (phase == 2) ? 70 : (phase == 3) ? 21 : 0;
            insert_pct     = (phase == 3) ? 25 : 4;
            if (phase == 0)
                holds_asked++;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(99);
                if (r < insert_pct)
                    queue_request(kvt_pkg::OP_INSERT, pick_key(), pick_value());
                else if (r < insert_pct + 5)
                    queue_request(OP_UNUSED, $urandom, $urandom);
                else if (r < insert_pct + 40)
                    queue_request(kvt_pkg::OP_UPSERT, pick_key(), pick_value());
                else
                    queue_request(kvt_pkg::OP_LOOKUP, pick_key(), $urandom);
            end
            wait_for_drain();
        end

        repeat (DRAIN_WAIT) @(negedge clk);
        $display("Sent %0d requests and checked %0d replies across four idling phases.",
                 requests_seen, replies_seen);
        $display("Lookup hits: %0d, refused insertions: %0d, peak fill: %0d of %0d pairs.",
                 lookup_hits, drops_seen, peak_pairs, CAP);
        if (errors == 0 && awaited_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
